[src/ldhs_pkg.sv]
// Shared types, codes and helpers for the load-data handshake sequencer.
package ldhs_pkg;

    localparam int LOAD_WORDS_DEF = 16;
    localparam int SEQ_W          = 5;
    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 48;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_SCHEME = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SCHEME = 2'd1,
        KIND_WORD   = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_POWER  = 2'd1;
    localparam logic [1:0] ERR_SPRING = 2'd2;

    localparam logic [31:0] SCHEME_CODE_1 = 32'd10;
    localparam logic [31:0] SCHEME_CODE_2 = 32'd20;
    localparam logic [31:0] SCHEME_CODE_3 = 32'd30;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_REQ  = 4'b0010,
        PH_ACK  = 4'b0100,
        PH_CONF = 4'b1000
    } link_phase_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

    function automatic logic [31:0] scheme_code(logic [2:0] s);
        logic [31:0] code;
        unique case (s)
            3'd1:    code = SCHEME_CODE_1;
            3'd2:    code = SCHEME_CODE_2;
            3'd3:    code = SCHEME_CODE_3;
            default: code = '0;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] phase_code(link_phase_t p);
        logic [1:0] code;
        unique case (p)
            PH_IDLE: code = 2'd0;
            PH_REQ:  code = 2'd1;
            PH_ACK:  code = 2'd2;
            PH_CONF: code = 2'd3;
            default: code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

[src/ldhs_ctrl.sv]
// Transaction sequencing controller: accept, execute, hold result.
module ldhs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output ldhs_pkg::ctrl_t ctrl
);
    import ldhs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_HOLD = 3'b100
    } ctl_state_t;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_HOLD;
            ST_HOLD:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_HOLD);
    assign ctrl.capture  = (state_reg == ST_IDLE) && s_axis_tvalid;
    assign ctrl.execute  = (state_reg == ST_EXEC);

    a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> ctrl.execute)
        else $error("execute did not follow an accepted transaction");

    a_exec_then_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |=> (m_axis_tvalid && !s_axis_tready))
        else $error("result not presented after execute");

endmodule

[src/ldhs_dp.sv]
// Datapath: load word table, link state registers and result register.
module ldhs_dp #(
    parameter int LOAD_WORDS = ldhs_pkg::LOAD_WORDS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ldhs_pkg::ctrl_t                   ctrl,
    input  logic [ldhs_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,
    output logic [ldhs_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser
);
    import ldhs_pkg::*;

    localparam int IDX_W = (LOAD_WORDS > 1) ? $clog2(LOAD_WORDS) : 1;

    // Table storage
    logic [31:0]           tbl_mem [LOAD_WORDS];
    logic [LOAD_WORDS-1:0] tbl_vld_reg;
    logic [31:0]           rd_data_reg;
    logic                  rd_vld_reg;

    // Captured transaction
    logic [IN_DATA_W-1:0]  item_reg;
    cmd_t                  item_cmd_reg;

    // Link state
    link_phase_t           phase_reg, phase_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic                  dirty_reg, dirty_next;
    logic                  vflag_reg, vflag_next;
    logic                  fin_reg, fin_next;
    logic [1:0]            err_reg, err_next;
    logic [2:0]            wanted_reg, wanted_next;

    // Result register
    logic                  out_f_reg;
    logic                  out_fwr_reg;
    logic [SEQ_W-1:0]      out_cnt_reg;
    logic                  out_cwr_reg;
    kind_t                 out_kind_reg;
    logic [31:0]           out_value_reg;
    logic [1:0]            out_err_reg;
    logic                  out_fin_reg;
    logic                  out_vld_reg;
    logic [1:0]            out_phase_reg;

    // Read address from the incoming transaction
    cmd_t                  in_cmd;
    logic [SEQ_W-1:0]      rd_addr_full;
    logic [IDX_W-1:0]      rd_addr;

    // Captured fields
    logic [3:0]            widx;
    logic [31:0]           wval;
    logic [2:0]            sval;
    logic                  power;
    logic                  relaxed;
    logic                  cmode;
    logic [1:0]            cur;
    logic                  pflag;
    logic [SEQ_W-1:0]      pcount;

    logic [31:0]           word_cur;
    logic [SEQ_W-1:0]      widx_full;
    logic                  widx_in_range;
    logic [IDX_W-1:0]      wr_addr;
    logic                  wr_en;
    logic [SEQ_W:0]        seq_inc;
    logic                  vflag_tick;
    logic [31:0]           code;
    logic                  f_out, f_wr, c_wr;
    kind_t                 kind;
    logic [31:0]           value;

    assign in_cmd       = cmd_t'(s_tuser);
    assign rd_addr_full = (in_cmd == CMD_WRITE) ? {1'b0, s_tdata[3:0]}
                                                : seq_reg - SEQ_W'(1);
    assign rd_addr      = (rd_addr_full < SEQ_W'(LOAD_WORDS)) ? rd_addr_full[IDX_W-1:0]
                                                              : '0;

    assign widx    = item_reg[3:0];
    assign wval    = item_reg[35:4];
    assign sval    = item_reg[38:36];
    assign power   = item_reg[39];
    assign relaxed = item_reg[40];
    assign cmode   = item_reg[41];
    assign cur     = item_reg[43:42];
    assign pflag   = item_reg[44];
    assign pcount  = item_reg[49:45];

    assign word_cur      = rd_vld_reg ? rd_data_reg : '0;
    assign widx_full     = {1'b0, widx};
    assign widx_in_range = widx_full < SEQ_W'(LOAD_WORDS);
    assign wr_addr       = widx_in_range ? widx_full[IDX_W-1:0] : '0;
    assign seq_inc       = {1'b0, seq_reg} + (SEQ_W+1)'(1);
    assign vflag_tick    = (!cmode && fin_reg) ? 1'b0 : vflag_reg;
    assign code          = scheme_code(wanted_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        dirty_next  = dirty_reg;
        vflag_next  = vflag_reg;
        fin_next    = fin_reg;
        err_next    = err_reg;
        wanted_next = wanted_reg;
        wr_en       = 1'b0;
        f_out       = 1'b0;
        f_wr        = 1'b0;
        c_wr        = 1'b0;
        kind        = KIND_NONE;
        value       = '0;
        unique case (item_cmd_reg)
            CMD_WRITE:
            begin
                if (widx_in_range && (word_cur != wval))
                begin
                    wr_en      = 1'b1;
                    dirty_next = 1'b1;
                end
            end
            CMD_SCHEME: wanted_next = sval;
            CMD_TICK:
            begin
                vflag_next = vflag_tick;
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (!vflag_tick || dirty_reg || ({1'b0, cur} != wanted_reg))
                        begin
                            if (!power)
                                err_next = ERR_POWER;
                            else if (!relaxed)
                                err_next = ERR_SPRING;
                            else if (code != '0)
                            begin
                                fin_next   = 1'b0;
                                seq_next   = SEQ_W'(1);
                                f_out      = 1'b1;
                                f_wr       = 1'b1;
                                kind       = KIND_SCHEME;
                                value      = code;
                                c_wr       = 1'b1;
                                phase_next = PH_REQ;
                            end
                            else
                                wanted_next = {1'b0, cur};
                        end
                        else
                        begin
                            err_next = ERR_NONE;
                            fin_next = 1'b1;
                        end
                    end
                    PH_REQ:
                    begin
                        if (pflag)
                            phase_next = PH_ACK;
                    end
                    PH_ACK:
                    begin
                        if (pflag)
                        begin
                            if (pcount == seq_reg)
                            begin
                                if (seq_inc >= (SEQ_W+1)'(2) &&
                                    seq_inc < (SEQ_W+1)'(LOAD_WORDS + 2))
                                begin
                                    kind  = KIND_WORD;
                                    value = word_cur;
                                end
                                else if (seq_inc == (SEQ_W+1)'(LOAD_WORDS + 2))
                                begin
                                    // drop the flag to close the transfer
                                    f_wr       = 1'b1;
                                    phase_next = PH_CONF;
                                end
                                seq_next = seq_inc[SEQ_W-1:0];
                                c_wr     = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            err_next   = ERR_NONE;
                            fin_next   = 1'b1;
                        end
                    end
                    PH_CONF:
                    begin
                        if (!pflag)
                        begin
                            phase_next = PH_IDLE;
                            fin_next   = 1'b1;
                            err_next   = ERR_NONE;
                            dirty_next = 1'b0;
                            vflag_next = 1'b1;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            CMD_NONE: ;
            default: ;
        endcase
    end

    // Table: registered read at capture, write at execute
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            rd_data_reg <= tbl_mem[rd_addr];
        if (ctrl.execute && wr_en)
            tbl_mem[wr_addr] <= wval;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
                rd_vld_reg <= tbl_vld_reg[rd_addr];
            if (ctrl.execute && wr_en)
                tbl_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg     <= s_tdata;
            item_cmd_reg <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            seq_reg       <= '0;
            dirty_reg     <= 1'b0;
            vflag_reg     <= 1'b0;
            fin_reg       <= 1'b1;
            err_reg       <= ERR_NONE;
            wanted_reg    <= '0;
            out_f_reg     <= 1'b0;
            out_fwr_reg   <= 1'b0;
            out_cnt_reg   <= '0;
            out_cwr_reg   <= 1'b0;
            out_kind_reg  <= KIND_NONE;
            out_value_reg <= '0;
            out_err_reg   <= ERR_NONE;
            out_fin_reg   <= 1'b1;
            out_vld_reg   <= 1'b0;
            out_phase_reg <= 2'd0;
        end
        else if (ctrl.execute)
        begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            dirty_reg     <= dirty_next;
            vflag_reg     <= vflag_next;
            fin_reg       <= fin_next;
            err_reg       <= err_next;
            wanted_reg    <= wanted_next;
            out_f_reg     <= f_out;
            out_fwr_reg   <= f_wr;
            out_cnt_reg   <= seq_next;
            out_cwr_reg   <= c_wr;
            out_kind_reg  <= kind;
            out_value_reg <= value;
            out_err_reg   <= err_next;
            out_fin_reg   <= fin_next;
            out_vld_reg   <= vflag_next;
            out_phase_reg <= phase_code(phase_next);
        end
    end

    assign m_tdata = {2'b00, out_phase_reg, out_vld_reg, out_fin_reg, out_err_reg,
                      out_value_reg, out_cwr_reg, out_cnt_reg, out_fwr_reg, out_f_reg};
    assign m_tuser = out_kind_reg;

    a_busy_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> !fin_reg)
        else $error("finished flag set while a transfer is open");

    a_word_sends_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_kind_reg == KIND_WORD) |-> (out_cwr_reg && out_phase_reg == 2'd2))
        else $error("load word sent without a count write in acknowledged phase");

    a_scheme_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_kind_reg == KIND_SCHEME) |->
            (out_cnt_reg == SEQ_W'(1) && out_f_reg && out_fwr_reg && out_phase_reg == 2'd1))
        else $error("scheme code sent outside a transfer start");

endmodule

[src/load_data_handshake_sequencer.sv]
// Top level of the load-data handshake sequencer.
//
//  channel   dir  tdata                                           tuser
//  s_axis    in   item: word_index .. partner_count (56 bits)      cmd
//  m_axis    out  result: flag_out .. link_phase (48 bits)         comm_kind
//
// One transaction at a time: accept, reading the load word table through a
// registered read port, then execute, then the result is held on m_axis.
// s_axis_tready is low from accept until the result transaction completes.
// A stalled result holds; reset clears link state and marks all table words
// invalid, so that they read as zero.
module load_data_handshake_sequencer #(
    parameter int LOAD_WORDS = ldhs_pkg::LOAD_WORDS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] word_index, [35:4] word_value, [38:36] scheme_value, [39] power_on,
    // [40] spring_relaxed, [41] command_mode, [43:42] current_scheme,
    // [44] partner_flag, [49:45] partner_count, [55:50] zero
    input  logic [ldhs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] flag_out, [1] flag_write, [6:2] count_out, [7] count_write,
    // [39:8] comm_value, [41:40] mode_error, [42] mode_finished,
    // [43] load_valid, [45:44] link_phase, [47:46] zero
    output logic [ldhs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [1:0] comm_kind
    output logic [1:0]                       m_axis_tuser
);
    import ldhs_pkg::*;

    ctrl_t ctrl;

    ldhs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .ctrl          (ctrl)
    );

    ldhs_dp #(
        .LOAD_WORDS (LOAD_WORDS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser),
        .m_tdata (m_axis_tdata),
        .m_tuser (m_axis_tuser)
    );

    a_one_side_open: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input open while a result is pending");

endmodule

[dv/load_data_handshake_sequencer_tb.sv]
// Testbench for the load-data handshake sequencer: directed table, partner-aware random items.
module load_data_handshake_sequencer_tb;
    import ldhs_pkg::*;

    localparam int N_WORDS  = LOAD_WORDS_DEF;
    localparam int N_RANDOM = 1050;
    localparam int N_DIR    = 23;

    typedef enum logic [1:0] {
        LP_IDLE = 2'd0,
        LP_REQ  = 2'd1,
        LP_ACK  = 2'd2,
        LP_CONF = 2'd3
    } link_ph_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  word_index;
        logic [31:0] word_value;
        logic [2:0]  scheme_value;
        logic        power_on;
        logic        spring_relaxed;
        logic        command_mode;
        logic [1:0]  current_scheme;
        logic        partner_flag;
        logic [4:0]  partner_count;
    } stim_t;

    typedef struct packed {
        logic        flag_out;
        logic        flag_write;
        logic [4:0]  count_out;
        logic        count_write;
        logic [1:0]  kind;
        logic [31:0] comm_value;
        logic [1:0]  mode_error;
        logic        mode_finished;
        logic        load_valid;
        logic [1:0]  link_phase;
    } result_t;

    typedef struct packed {
        stim_t   stim;
        logic    typed;
        result_t want;
    } dir_row_t;

    localparam result_t NO_RESULT = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    // sequencer state mirrored by the predictor
    link_ph_t    link_ph;
    logic [4:0]  seq_count;
    logic [31:0] load_words [N_WORDS];
    logic        words_dirty;
    logic        partner_valid;
    logic        xfer_finished;
    logic [1:0]  err_code;
    logic [2:0]  wanted_scheme;

    result_t expected_q [$];
    int      mismatches;
    int      n_checked;
    int      n_confirm;
    int      n_abort;
    int      n_quiet;
    int      send_idle_pct;
    int      recv_idle_pct;

    // cmd, index, value, scheme, power, relaxed, cmode, cur, pflag, pcount | typed | result
    dir_row_t dir_rows [N_DIR] = '{
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b0, 1'b1, 1'b1, 2'd0, 1'b0, 5'd0}, 1'b1,
          '{1'b0, 1'b0, 5'd0, 1'b0, KIND_NONE, 32'd0, ERR_POWER, 1'b1, 1'b0, LP_IDLE}},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b0, 1'b1, 2'd0, 1'b0, 5'd0}, 1'b1,
          '{1'b0, 1'b0, 5'd0, 1'b0, KIND_NONE, 32'd0, ERR_SPRING, 1'b1, 1'b0, LP_IDLE}},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd3, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_NONE, 4'd15, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 1'b1, 2'd3, 1'b1, 5'd31},
          1'b0, NO_RESULT},
        '{'{CMD_SCHEME, 4'd15, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 1'b1, 2'd3, 1'b1, 5'd31},
          1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd2, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_WRITE, 4'd0, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0},
          1'b0, NO_RESULT},
        '{'{CMD_WRITE, 4'd15, 32'd0, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_WRITE, 4'd15, 32'h8000_0001, 3'd0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0},
          1'b0, NO_RESULT},
        '{'{CMD_SCHEME, 4'd0, 32'd0, 3'd3, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b0, 1'b1, 1'b1, 2'd0, 1'b0, 5'd0}, 1'b1,
          '{1'b0, 1'b0, 5'd0, 1'b0, KIND_NONE, 32'd0, ERR_POWER, 1'b1, 1'b0, LP_IDLE}},
        // start with the power error still standing, monitor state
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b0, 2'd0, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1, 5'd31}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1, 5'd1}, 1'b0, NO_RESULT},
        '{'{CMD_WRITE, 4'd1, 32'h1234_5678, 3'd0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1, 5'd0},
          1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1, 5'd2}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd0, 1'b0, 5'd3}, 1'b1,
          '{1'b0, 1'b0, 5'd3, 1'b0, KIND_NONE, 32'd0, ERR_NONE, 1'b1, 1'b0, LP_IDLE}},
        '{'{CMD_SCHEME, 4'd0, 32'd0, 3'd1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd1, 1'b0, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd1, 1'b1, 5'd0}, 1'b0, NO_RESULT},
        '{'{CMD_TICK, 4'd0, 32'd0, 3'd0, 1'b1, 1'b1, 1'b1, 2'd1, 1'b0, 5'd0}, 1'b0, NO_RESULT}
    };

    load_data_handshake_sequencer #(
        .LOAD_WORDS(N_WORDS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the mirrored sequencer by one transaction and return its result.
    function automatic result_t sequencer_step(input stim_t s);
        result_t r;
        int      nxt;
        r = NO_RESULT;
        case (s.cmd)
            CMD_WRITE:
            begin
                if (int'(s.word_index) < N_WORDS && load_words[s.word_index] != s.word_value)
                begin
                    load_words[s.word_index] = s.word_value;
                    words_dirty = 1'b1;
                end
            end
            CMD_SCHEME: wanted_scheme = s.scheme_value;
            CMD_TICK:
            begin
                if (!s.command_mode && xfer_finished)
                    partner_valid = 1'b0;
                case (link_ph)
                    LP_IDLE:
                    begin
                        if (!partner_valid || words_dirty || {1'b0, s.current_scheme} != wanted_scheme)
                        begin
                            if (!s.power_on)
                                err_code = ERR_POWER;
                            else if (!s.spring_relaxed)
                                err_code = ERR_SPRING;
                            else if (wanted_scheme >= 3'd1 && wanted_scheme <= 3'd3)
                            begin
                                case (wanted_scheme)
                                    3'd1:    r.comm_value = SCHEME_CODE_1;
                                    3'd2:    r.comm_value = SCHEME_CODE_2;
                                    default: r.comm_value = SCHEME_CODE_3;
                                endcase
                                xfer_finished = 1'b0;
                                seq_count     = 5'd1;
                                r.flag_out    = 1'b1;
                                r.flag_write  = 1'b1;
                                r.count_write = 1'b1;
                                r.kind        = KIND_SCHEME;
                                link_ph       = LP_REQ;
                            end
                            else
                                // fall back to whatever the partner runs
                                wanted_scheme = {1'b0, s.current_scheme};
                        end
                        else
                        begin
                            err_code      = ERR_NONE;
                            xfer_finished = 1'b1;
                            n_quiet++;
                        end
                    end
                    LP_REQ:
                    begin
                        if (s.partner_flag)
                            link_ph = LP_ACK;
                    end
                    LP_ACK:
                    begin
                        if (!s.partner_flag)
                        begin
                            link_ph       = LP_IDLE;
                            err_code      = ERR_NONE;
                            xfer_finished = 1'b1;
                            n_abort++;
                        end
                        else if (s.partner_count == seq_count)
                        begin
                            nxt = int'(seq_count) + 1;
                            if (nxt >= 2 && nxt < N_WORDS + 2)
                            begin
                                r.kind       = KIND_WORD;
                                r.comm_value = load_words[nxt - 2];
                            end
                            else if (nxt == N_WORDS + 2)
                            begin
                                r.flag_write = 1'b1;
                                link_ph      = LP_CONF;
                            end
                            seq_count     = 5'(nxt);
                            r.count_write = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!s.partner_flag)
                        begin
                            link_ph       = LP_IDLE;
                            xfer_finished = 1'b1;
                            err_code      = ERR_NONE;
                            words_dirty   = 1'b0;
                            partner_valid = 1'b1;
                            n_confirm++;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        r.count_out     = seq_count;
        r.mode_error    = err_code;
        r.mode_finished = xfer_finished;
        r.load_valid    = partner_valid;
        r.link_phase    = link_ph;
        return r;
    endfunction

    // Mostly a cooperative partner with random content; the rest is noise.
    function automatic stim_t partner_item();
        stim_t s;
        int    pick;
        s.cmd            = CMD_TICK;
        s.word_index     = 4'($urandom_range(0, 15));
        s.word_value     = $urandom();
        s.scheme_value   = 3'($urandom_range(0, 7));
        s.power_on       = ($urandom_range(0, 99) < 92);
        s.spring_relaxed = ($urandom_range(0, 99) < 92);
        s.command_mode   = ($urandom_range(0, 99) < 90);
        s.current_scheme = 2'($urandom_range(0, 3));
        s.partner_flag   = 1'($urandom_range(0, 1));
        s.partner_count  = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 9)
        begin
            s.cmd = CMD_WRITE;
            case ($urandom_range(0, 3))
                2:       s.word_value = load_words[s.word_index];
                3:       s.word_value = {32{s.word_value[0]}};
                default: ;
            endcase
        end
        else if (pick < 14)
        begin
            s.cmd = CMD_SCHEME;
            if ($urandom_range(0, 99) < 80)
                s.scheme_value = 3'($urandom_range(1, 3));
        end
        else if (pick < 16)
            s.cmd = CMD_NONE;
        else
        begin
            if (wanted_scheme <= 3'd3 && $urandom_range(0, 99) < 75)
                s.current_scheme = wanted_scheme[1:0];
            case (link_ph)
                LP_REQ:  s.partner_flag = ($urandom_range(0, 99) < 90);
                LP_ACK:
                begin
                    s.partner_flag = ($urandom_range(0, 99) < 97);
                    if ($urandom_range(0, 99) < 88)
                        s.partner_count = seq_count;
                end
                LP_CONF: s.partner_flag = ($urandom_range(0, 99) < 15);
                default: ;
            endcase
        end
        return s;
    endfunction

    function automatic string result_str(input result_t r);
        return $sformatf("flag=%0d/%0d cnt=%0d/%0d kind=%0d val=%h err=%0d fin=%0d vld=%0d ph=%0d",
                         r.flag_out, r.flag_write, r.count_out, r.count_write, r.kind,
                         r.comm_value, r.mode_error, r.mode_finished, r.load_valid,
                         r.link_phase);
    endfunction

    task automatic send_item(input stim_t s, input logic typed, input result_t want);
        result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tdata  = {6'd0, s.partner_count, s.partner_flag, s.current_scheme,
                         s.command_mode, s.spring_relaxed, s.power_on, s.scheme_value,
                         s.word_value, s.word_index};
        s_axis_tuser  = s.cmd;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = sequencer_step(s);
        expected_q.insert(expected_q.size(), typed ? want : predicted);
        @(negedge clk);
    endtask

    // receiver stalls
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.flag_out      = m_axis_tdata[0];
            got.flag_write    = m_axis_tdata[1];
            got.count_out     = m_axis_tdata[6:2];
            got.count_write   = m_axis_tdata[7];
            got.kind          = m_axis_tuser;
            got.comm_value    = m_axis_tdata[39:8];
            got.mode_error    = m_axis_tdata[41:40];
            got.mode_finished = m_axis_tdata[42];
            got.load_valid    = m_axis_tdata[43];
            got.link_phase    = m_axis_tdata[45:44];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %s", result_str(got));
            end
            else
            begin
                want = expected_q.pop_front();
                n_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on result %0d", n_checked);
                        $display("  expected %s", result_str(want));
                        $display("  actual   %s", result_str(got));
                    end
                end
            end
        end
    end

    initial
    begin
        #2_500_000;
        $display("timeout: %0d results still pending", expected_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_TICK;
        link_ph       = LP_IDLE;
        seq_count     = 5'd0;
        foreach (load_words[i])
            load_words[i] = 32'd0;
        words_dirty   = 1'b0;
        partner_valid = 1'b0;
        xfer_finished = 1'b1;
        err_code      = ERR_NONE;
        wanted_scheme = 3'd0;
        mismatches    = 0;
        n_checked     = 0;
        n_confirm     = 0;
        n_abort       = 0;
        n_quiet       = 0;
        send_idle_pct = 15;
        recv_idle_pct = 61;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM / 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 15;
            end
            else if (k == 2 * N_RANDOM / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(partner_item(), 1'b0, NO_RESULT);
        end
        s_axis_tvalid = 1'b0;

        // drain, then wait for stray transactions
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d results: %0d transfers confirmed, %0d aborted, %0d idle ticks with nothing pending",
                 n_checked, n_confirm, n_abort, n_quiet);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
